@@ design/efs_pkg.sv @@
// Package for the event flag scheduler: request/response types, codes, states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package efs_pkg;
   localparam int TASKS_DEF = 8;
   localparam int EVENTS_DEF = 32;
   localparam int TICK_WIDTH_DEF = 32;

   typedef enum logic [2:0] {
      OP_TICK = 3'd0, OP_START = 3'd1, OP_STOP = 3'd2, OP_POST = 3'd3,
      OP_POLL = 3'd4, OP_REPORT = 3'd5, OP_QUERY = 3'd6, OP_BAD = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SWEEP, ST_SWEEP_WB, ST_SINGLE, ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [2:0]  task_index;
      logic [4:0]  event_bit;
      logic [31:0] amount;
   } req_type_t_type;

   typedef struct packed {
      logic [31:0] flags_taken;
      logic [2:0]  polled_task;
      logic        wrapped_idle;
      logic [31:0] value;
      logic        accepted;
   } rsp_type;
endpackage
`default_nettype wire

@@ design/efs_ram.sv @@
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module efs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

@@ design/event_flag_scheduler_with_timers.sv @@
// Top level: event flag scheduler with per-event one-shot timers.
// Uses efs_pkg and efs_ram (timer remaining counts).
//
//  channel | ports                    | direction
//  request | req_valid/req_stall/req  | in
//  result  | rsp_valid/rsp_stall/rsp  | out
//  config  | csr_we/csr_wdata         | in
// Tick pass and next-deadline query: sweep of all TASKS*EVENTS_PER_TASK entries,
// one per cycle through the single RAM read port and shared subtract/compare.
// Other requests skip the sweep. Result held in an output register until taken.
// Reset clears flags, running bits, maxima, scan pointer; task count becomes 8.
// Timer RAM needs no clearing: an entry is read only while its timer runs.
`timescale 1ns / 1ps
`default_nettype none
module event_flag_scheduler_with_timers #(
   parameter int TASKS = efs_pkg::TASKS_DEF,
   parameter int EVENTS_PER_TASK = efs_pkg::EVENTS_DEF,
   parameter int TICK_WIDTH = efs_pkg::TICK_WIDTH_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire efs_pkg::req_type_t_type req,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output efs_pkg::rsp_type             rsp,
   input  wire logic                    csr_we,
   input  wire logic [3:0]              csr_wdata
);
   import efs_pkg::*;
   localparam int NT = TASKS * EVENTS_PER_TASK;
   localparam int AW = (NT > 1) ? $clog2(NT) : 1;
   localparam int TW = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam int EW = (EVENTS_PER_TASK > 1) ? $clog2(EVENTS_PER_TASK) : 1;

   state_type state_ff, state_in;
   req_type_t_type req_ff;
   logic [3:0] count_ff;
   logic [EVENTS_PER_TASK-1:0] flags_ff [TASKS];
   logic [NT-1:0] run_ff;
   logic [31:0] longest_ff [TASKS];
   logic [TW-1:0] scan_ff;
   logic [AW:0] idx_ff, idx_in;
   logic [AW-1:0] rd_idx_ff;
   logic [TICK_WIDTH-1:0] best_ff;
   logic any_ff;
   rsp_type rsp_ff;
   logic rsp_valid_ff;

   logic wr_en;
   logic [AW-1:0] wr_addr;
   logic [TICK_WIDTH-1:0] wr_data, rd_data, tick;
   logic task_ok, idx_ok;
   logic [AW-1:0] tix;
   logic [TW-1:0] tsk;
   logic [EW-1:0] ebit;

   assign tick = TICK_WIDTH'(req_ff.amount);
   assign task_ok = 32'(req_ff.task_index) < TASKS;
   assign idx_ok = task_ok && (32'(req_ff.event_bit) < EVENTS_PER_TASK);
   assign tsk = TW'(req_ff.task_index);
   assign ebit = EW'(req_ff.event_bit);
   assign tix = AW'(32'(req_ff.task_index) * EVENTS_PER_TASK + 32'(req_ff.event_bit));

   efs_ram #(.WIDTH(TICK_WIDTH), .DEPTH(NT)) u_rem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(AW'(idx_ff)), .rd_data(rd_data));

   assign req_stall = (state_ff != ST_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid && !req_stall) begin
            idx_in = '0;
            state_in = ST_SINGLE;
            if (req.req_type == OP_TICK && TICK_WIDTH'(req.amount) != '0)
               state_in = ST_SWEEP;
            if (req.req_type == OP_QUERY && req.amount == 32'd1) state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            idx_in = idx_ff + 1'b1;
            state_in = ST_SWEEP_WB;
         end
         ST_SWEEP_WB: begin
            if (32'(idx_ff) >= NT) state_in = ST_SINGLE;
            else idx_in = idx_ff + 1'b1;
         end
         ST_SINGLE: state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // write port: sweep writeback of decremented count, or start
   always_comb begin
      wr_en = 1'b0;
      wr_addr = rd_idx_ff;
      wr_data = rd_data - tick;
      if (state_ff == ST_SWEEP_WB && req_ff.req_type == OP_TICK &&
          run_ff[rd_idx_ff] && rd_data > tick)
         wr_en = 1'b1;
      if (state_ff == ST_SINGLE && req_ff.req_type == OP_START && idx_ok) begin
         wr_en = 1'b1;
         wr_addr = tix;
         wr_data = tick;
      end
   end

   logic [3:0] cnt;
   always_comb begin
      cnt = count_ff;
      if (cnt == 4'd0) cnt = 4'd1;
      if (32'(cnt) > TASKS) cnt = 4'(TASKS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= 4'd8;
         run_ff <= '0;
         scan_ff <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff <= '0;
         for (int i = 0; i < TASKS; i++) begin
            flags_ff[i] <= '0;
            longest_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         rd_idx_ff <= AW'(idx_ff);
         if (csr_we) count_ff <= csr_wdata;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (req_valid && !req_stall) begin
               req_ff <= req;
               any_ff <= 1'b0;
               best_ff <= '0;
            end
            ST_SWEEP_WB: if (run_ff[rd_idx_ff]) begin
               if (req_ff.req_type == OP_TICK) begin
                  if (rd_data <= tick) begin
                     run_ff[rd_idx_ff] <= 1'b0;
                     flags_ff[32'(rd_idx_ff) / EVENTS_PER_TASK]
                        [32'(rd_idx_ff) % EVENTS_PER_TASK] <= 1'b1;
                  end
               end else if (!any_ff || rd_data < best_ff) begin
                  best_ff <= rd_data;
                  any_ff <= 1'b1;
               end
            end
            ST_SINGLE: begin
               rsp_ff <= '0;
               case (req_ff.req_type)
                  OP_TICK: rsp_ff.accepted <= 1'b1;
                  OP_START: if (idx_ok) begin
                     run_ff[tix] <= 1'b1;
                     rsp_ff.accepted <= 1'b1;
                  end
                  OP_STOP: if (idx_ok && run_ff[tix]) begin
                     run_ff[tix] <= 1'b0;
                     rsp_ff.accepted <= 1'b1;
                  end
                  OP_POST: if (idx_ok) begin
                     flags_ff[tsk][ebit] <= 1'b1;
                     rsp_ff.accepted <= 1'b1;
                  end
                  OP_POLL: begin
                     rsp_ff.flags_taken <= 32'(flags_ff[scan_ff]);
                     rsp_ff.polled_task <= 3'(scan_ff);
                     rsp_ff.accepted <= 1'b1;
                     flags_ff[scan_ff] <= '0;
                     if (flags_ff[scan_ff] != '0) scan_ff <= '0;
                     else if (32'(scan_ff) + 1 < 32'(cnt)) scan_ff <= scan_ff + 1'b1;
                     else begin
                        scan_ff <= '0;
                        rsp_ff.wrapped_idle <= 1'b1;
                     end
                  end
                  OP_REPORT: if (task_ok) begin
                     if (req_ff.amount > longest_ff[tsk]) longest_ff[tsk] <= req_ff.amount;
                     rsp_ff.accepted <= 1'b1;
                  end
                  OP_QUERY: begin
                     if (req_ff.amount == 32'd0 && task_ok) begin
                        rsp_ff.value <= longest_ff[tsk];
                        rsp_ff.accepted <= 1'b1;
                     end else if (req_ff.amount == 32'd1) begin
                        rsp_ff.value <= 32'(best_ff);
                        rsp_ff.accepted <= 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            ST_DONE: rsp_valid_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall) else $error("accept while busy");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_valid) else $error("missing result");
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      32'(scan_ff) < TASKS) else $error("scan pointer out of range");
endmodule
`default_nettype wire
